// ===== hw/rtl/dla_pkg.sv =====
// Shared constants and types for the DAG layer assignment block.
package dla_pkg;

    localparam int MaxNodes = 64;
    localparam int MaxEdges = 256;
    localparam int NodeW = $clog2(MaxNodes);
    localparam int EdgeW = $clog2(MaxEdges);
    localparam int EcntW = $clog2(MaxEdges + 1);
    localparam int CountW = 7;
    localparam int DegW = EcntW;

    // One stored edge: source and target node numbers.
    typedef struct packed {
        logic [NodeW-1:0] src;
        logic [NodeW-1:0] tgt;
    } t_edge;

    // Edge store access from the sequencer.
    typedef struct packed {
        logic             we;
        logic [EdgeW-1:0] waddr;
        t_edge            wdata;
        logic [EdgeW-1:0] raddr;
    } t_edge_req;

endpackage

// ===== hw/rtl/dla_edge_ram.sv =====
// Edge store: one write port and one registered read port.
module dla_edge_ram (
    input  logic                      i_clk,
    input  dla_pkg::t_edge_req        i_req,
    output dla_pkg::t_edge            o_rdata
);

    dla_pkg::t_edge r_mem [dla_pkg::MaxEdges];

    // Synchronous write and read.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

// ===== hw/rtl/dag_layer_assignment_core.sv =====
// Top level of the DAG layer assignment block: edge loading, layering and output.
// An edge without the last mark is taken while loading. On the last edge the block clears
// node and queue state, counts in-degrees, seeds the queue, walks the edge store for each
// queued node, then emits one result per node, holding each while the result side stalls.
// No new edge or node count is taken until the last result of the graph has been accepted.
// Reset (synchronous, active low) clears control state and the node count goes to 64.
module dag_layer_assignment_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_node_count,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [5:0] i_edge_source,
    input  logic [5:0] i_edge_target,
    input  logic       i_edge_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [5:0] o_node_id,
    output logic [5:0] o_layer,
    output logic [5:0] o_row,
    output logic       o_unplaced,
    output logic       o_edges_dropped,
    output logic       o_result_last
);

    typedef enum logic [3:0] {
        S_LOAD, S_CLEAR, S_COUNT, S_SEED, S_POP, S_POP_Q, S_POP_L, S_WALK,
        S_EMIT, S_EMIT_L, S_EMIT_R
    } t_state;

    localparam int NW = dla_pkg::NodeW;
    localparam int EW = dla_pkg::EdgeW;
    localparam int CW = dla_pkg::EcntW;
    localparam int DW = dla_pkg::DegW;

    // Per node word: in-degree, layer and placed flag.
    typedef struct packed {
        logic [DW-1:0] deg;
        logic [NW-1:0] lay;
        logic          placed;
    } t_node;

    // Per index word: layer fill count and ready queue slot.
    typedef struct packed {
        logic [NW:0]   fill;
        logic [NW-1:0] qnode;
    } t_aux;

    t_state r_state;
    logic [dla_pkg::CountW-1:0] r_count;
    logic [CW-1:0] r_etotal;
    logic          r_drop;
    logic [CW-1:0] r_eidx;      // read address issued
    logic          r_rvalid;    // read data valid this cycle
    logic          r_p_valid;   // node read data valid this cycle
    logic [NW-1:0] r_p_node;
    logic [NW:0]   r_nidx;
    logic [NW:0]   r_head, r_tail;
    logic [NW-1:0] r_cur;
    logic [NW-1:0] r_curlay;
    logic          r_curplc;

    // Node memory and layer fill / queue memory, with registered reads.
    t_node         r_node_mem [dla_pkg::MaxNodes];
    t_node         r_node_rd;
    logic [NW-1:0] r_nraddr;
    logic          r_nbyp_we;
    logic [NW-1:0] r_nbyp_addr;
    t_node         r_nbyp_data;
    t_aux          r_aux_mem [dla_pkg::MaxNodes];
    t_aux          r_aux_rd;
    logic [NW-1:0] r_araddr;
    logic          r_abyp_we;
    logic [NW-1:0] r_abyp_addr;
    t_aux          r_abyp_data;

    logic          w_nwe;
    logic [NW-1:0] w_nraddr;
    logic [NW-1:0] w_nwaddr;
    t_node         w_nwdata;
    t_node         w_node;
    logic          w_awe;
    logic [NW-1:0] w_araddr;
    logic [NW-1:0] w_awaddr;
    t_aux          w_awdata;
    t_aux          w_aux;

    dla_pkg::t_edge_req w_req;
    dla_pkg::t_edge     w_rdata;

    logic [NW:0] w_n;
    logic        w_acc;
    logic        w_bad;
    logic        w_walk_done;
    logic        w_rd_ok;
    logic        w_hit;
    logic        w_dec;
    logic        w_free;
    logic        w_seed;
    logic        w_emit_go;

    dla_edge_ram u_ram (.i_clk(i_clk), .i_req(w_req), .o_rdata(w_rdata));

    // Active node count, clamped.
    always_comb begin
        if (r_count == '0) begin
            w_n = (NW+1)'(1);
        end else if (r_count > dla_pkg::CountW'(dla_pkg::MaxNodes)) begin
            w_n = (NW+1)'(dla_pkg::MaxNodes);
        end else begin
            w_n = r_count[NW:0];
        end
    end

    assign o_ready     = (r_state == S_LOAD);
    assign o_cfg_ready = (r_state == S_LOAD);
    assign w_acc       = i_valid && o_ready;
    assign w_bad = ({1'b0, i_edge_source} >= w_n) || ({1'b0, i_edge_target} >= w_n)
                   || (r_etotal >= CW'(dla_pkg::MaxEdges));
    assign w_walk_done = (r_eidx >= r_etotal) && !r_rvalid && !r_p_valid;

    // Read data with the write of the same edge forwarded.
    assign w_node = (r_nbyp_we && r_nbyp_addr == r_nraddr) ? r_nbyp_data : r_node_rd;
    assign w_aux  = (r_abyp_we && r_abyp_addr == r_araddr) ? r_abyp_data : r_aux_rd;

    // Decisions on the stored edge and node words.
    assign w_rd_ok   = ({1'b0, w_rdata.src} < w_n) && ({1'b0, w_rdata.tgt} < w_n);
    assign w_hit     = (w_rdata.src == r_cur) && ({1'b0, w_rdata.tgt} < w_n);
    assign w_dec     = r_p_valid && (w_node.deg != '0);
    assign w_free    = w_dec && (w_node.deg == DW'(1))
                       && (r_tail < (NW+1)'(dla_pkg::MaxNodes));
    assign w_seed    = r_p_valid && (w_node.deg == '0);
    assign w_emit_go = !o_valid || i_ready;

    // Edge store port.
    always_comb begin
        w_req.we        = w_acc && !w_bad;
        w_req.waddr     = r_etotal[EW-1:0];
        w_req.wdata.src = i_edge_source;
        w_req.wdata.tgt = i_edge_target;
        w_req.raddr     = r_eidx[EW-1:0];
    end

    // Node and fill / queue memory ports.
    always_comb begin
        w_nraddr       = w_rdata.tgt;
        w_nwe          = 1'b0;
        w_nwaddr       = r_p_node;
        w_nwdata       = w_node;
        w_araddr       = r_head[NW-1:0];
        w_awe          = 1'b0;
        w_awaddr       = r_tail[NW-1:0];
        w_awdata.fill  = '0;
        w_awdata.qnode = r_p_node;
        case (r_state)
            S_CLEAR: begin
                w_nwe    = 1'b1;
                w_nwaddr = r_nidx[NW-1:0];
                w_nwdata = '0;
                w_awe    = 1'b1;
                w_awaddr = r_nidx[NW-1:0];
                w_awdata = '0;
            end
            S_COUNT: begin
                w_nwe        = r_p_valid;
                w_nwdata.deg = w_node.deg + DW'(1);
            end
            S_SEED: begin
                w_nraddr        = r_nidx[NW-1:0];
                w_nwe           = w_seed;
                w_nwdata.placed = 1'b1;
                w_awe           = w_seed;
            end
            S_POP_Q: begin
                w_nraddr = w_aux.qnode;
            end
            S_WALK: begin
                w_nwe        = w_dec;
                w_nwdata.deg = w_node.deg - DW'(1);
                if (w_free) begin
                    w_nwdata.lay    = r_curlay + NW'(1);
                    w_nwdata.placed = 1'b1;
                end
                w_awe = w_free;
            end
            S_EMIT: begin
                w_nraddr = r_nidx[NW-1:0];
            end
            S_EMIT_L: begin
                w_araddr = w_node.lay;
            end
            S_EMIT_R: begin
                w_araddr       = r_curlay;
                w_awe          = w_emit_go;
                w_awaddr       = r_curlay;
                w_awdata.fill  = w_aux.fill + (NW+1)'(1);
                w_awdata.qnode = w_aux.qnode;
            end
            default: begin
            end
        endcase
    end

    // Node memory: synchronous write and registered read.
    always_ff @(posedge i_clk) begin
        if (w_nwe) begin
            r_node_mem[w_nwaddr] <= w_nwdata;
        end
        r_node_rd <= r_node_mem[w_nraddr];
        r_nraddr  <= w_nraddr;
    end

    // Fill / queue memory: synchronous write and registered read.
    always_ff @(posedge i_clk) begin
        if (w_awe) begin
            r_aux_mem[w_awaddr] <= w_awdata;
        end
        r_aux_rd <= r_aux_mem[w_araddr];
        r_araddr <= w_araddr;
    end

    // Last write of each memory, for reads issued at the same edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nbyp_we <= 1'b0;
            r_abyp_we <= 1'b0;
        end else begin
            r_nbyp_we <= w_nwe;
            r_abyp_we <= w_awe;
        end
        r_nbyp_addr <= w_nwaddr;
        r_nbyp_data <= w_nwdata;
        r_abyp_addr <= w_awaddr;
        r_abyp_data <= w_awdata;
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= dla_pkg::CountW'(dla_pkg::MaxNodes);
            r_etotal  <= '0;
            r_drop    <= 1'b0;
            r_eidx    <= '0;
            r_rvalid  <= 1'b0;
            r_p_valid <= 1'b0;
            r_nidx    <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            o_valid   <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (i_cfg_valid) begin
                        r_count <= i_node_count;
                    end
                    if (w_acc) begin
                        if (w_bad) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_etotal <= r_etotal + CW'(1);
                        end
                        if (i_edge_last) begin
                            r_state <= S_CLEAR;
                            r_nidx  <= '0;
                        end
                    end
                end
                // One node and one fill / queue word cleared per cycle.
                S_CLEAR: begin
                    if (r_nidx == (NW+1)'(dla_pkg::MaxNodes - 1)) begin
                        r_eidx    <= '0;
                        r_rvalid  <= 1'b0;
                        r_p_valid <= 1'b0;
                        r_state   <= S_COUNT;
                    end
                    r_nidx <= r_nidx + (NW+1)'(1);
                end
                S_COUNT: begin
                    if (r_eidx < r_etotal) begin
                        r_eidx <= r_eidx + CW'(1);
                    end
                    r_rvalid  <= (r_eidx < r_etotal);
                    r_p_valid <= r_rvalid && w_rd_ok;
                    r_p_node  <= w_rdata.tgt;
                    if (r_rvalid && !w_rd_ok) begin
                        r_drop <= 1'b1;
                    end
                    if (w_walk_done) begin
                        r_state <= S_SEED;
                        r_nidx  <= '0;
                        r_head  <= '0;
                        r_tail  <= '0;
                    end
                end
                S_SEED: begin
                    r_p_valid <= (r_nidx < w_n);
                    r_p_node  <= r_nidx[NW-1:0];
                    if (r_nidx < w_n) begin
                        r_nidx <= r_nidx + (NW+1)'(1);
                    end
                    if (w_seed) begin
                        r_tail <= r_tail + (NW+1)'(1);
                    end
                    if (r_nidx >= w_n && !r_p_valid) begin
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    if (r_head < r_tail) begin
                        r_head  <= r_head + (NW+1)'(1);
                        r_state <= S_POP_Q;
                    end else begin
                        r_nidx  <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_POP_Q: begin
                    r_cur   <= w_aux.qnode;
                    r_state <= S_POP_L;
                end
                S_POP_L: begin
                    r_curlay  <= w_node.lay;
                    r_eidx    <= '0;
                    r_rvalid  <= 1'b0;
                    r_p_valid <= 1'b0;
                    r_state   <= S_WALK;
                end
                S_WALK: begin
                    if (r_eidx < r_etotal) begin
                        r_eidx <= r_eidx + CW'(1);
                    end
                    r_rvalid  <= (r_eidx < r_etotal);
                    r_p_valid <= r_rvalid && w_hit;
                    r_p_node  <= w_rdata.tgt;
                    if (w_free) begin
                        r_tail <= r_tail + (NW+1)'(1);
                    end
                    if (w_walk_done) begin
                        r_state <= S_POP;
                    end
                end
                S_EMIT: begin
                    if (r_nidx < w_n) begin
                        o_valid <= o_valid && !i_ready;
                        r_state <= S_EMIT_L;
                    end else if (w_emit_go) begin
                        o_valid  <= 1'b0;
                        r_etotal <= '0;
                        r_drop   <= 1'b0;
                        r_state  <= S_LOAD;
                    end
                end
                S_EMIT_L: begin
                    o_valid  <= o_valid && !i_ready;
                    r_curlay <= w_node.lay;
                    r_curplc <= w_node.placed;
                    r_state  <= S_EMIT_R;
                end
                S_EMIT_R: begin
                    if (w_emit_go) begin
                        o_valid         <= 1'b1;
                        o_node_id       <= r_nidx[NW-1:0];
                        o_layer         <= r_curlay;
                        o_row           <= w_aux.fill[NW-1:0];
                        o_unplaced      <= !r_curplc;
                        o_edges_dropped <= r_drop;
                        o_result_last   <= (r_nidx + (NW+1)'(1) == w_n);
                        r_nidx          <= r_nidx + (NW+1)'(1);
                        r_state         <= S_EMIT;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // No edge is taken while results are pending.
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("edge accepted during output");
    // The queue never runs past its tail.
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head passed tail");
    // Stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_node_id))
        else $error("result changed while stalled");
`endif

endmodule
